// ===== rtl/boosted_stump_cascade_eval_macros.svh =====
// assertion macros used by the port-level checker file
`ifndef BOOSTED_STUMP_CASCADE_EVAL_MACROS_SVH
`define BOOSTED_STUMP_CASCADE_EVAL_MACROS_SVH
// implication checked every clock outside reset
`define BSC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define BSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/bsc_pkg.sv =====
// shared types and constants of the stump cascade evaluator
package bsc_pkg;
  localparam int Features = 256;
  localparam int Stumps   = 256;
  localparam int Stages   = 16;
  localparam int FiW = $clog2(Features);
  localparam int SkW = $clog2(Stumps);
  localparam int SgW = $clog2(Stages);

  typedef enum logic [1:0] {
    ACT_LOAD_FEATURE = 2'd0,
    ACT_LOAD_STUMP   = 2'd1,
    ACT_LOAD_STAGE   = 2'd2,
    ACT_EVALUATE     = 2'd3
  } action_t;

  localparam logic [1:0] REG_BOOST_MODE = 2'd0;
  localparam logic [1:0] REG_STAGES     = 2'd1;

  // one queued transaction between front and back
  typedef struct packed {
    action_t     action;
    logic [7:0]  entry_index;
    logic [15:0] feature_value;
    logic [7:0]  stump_feature;
    logic        stump_dir_negative;
    logic [15:0] stump_thresh;
    logic [15:0] stump_weight;
    logic [15:0] stump_pos_out;
    logic [15:0] stump_neg_out;
    logic [7:0]  stage_size;
    logic [15:0] stage_thresh;
  } cmd_t;

  // saturating 32 bit add
  function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
                                                logic signed [16:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s > 33'sd2147483647) return 32'sh7fffffff;
    if (s < -33'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction
endpackage

// ===== rtl/bsc_front.sv =====
// front end: a two-entry command queue
module bsc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  bsc_pkg::cmd_t   in_cmd,
  output logic            q_valid,
  input  logic            q_take,
  output bsc_pkg::cmd_t   q_cmd
);
  bsc_pkg::cmd_t mem [2];
  logic          wp, rp;
  logic [1:0]    cnt;

  assign in_stall = cnt[1];
  assign q_valid  = cnt != 2'd0;
  assign q_cmd    = mem[rp];

  // queue pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (in_valid && !in_stall) wp <= ~wp;
      if (q_take) rp <= ~rp;
      cnt <= cnt + 2'(in_valid && !in_stall) - 2'(q_take);
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) mem[wp] <= in_cmd;
  end
endmodule

// ===== rtl/bsc_back.sv =====
// back end: stores, stump walk and result register
module bsc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_take,
  input  bsc_pkg::cmd_t       q_cmd,
  input  logic                boost_mode,
  input  logic [4:0]          stages_in_use,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                rejected,
  output logic [3:0]          reject_stage,
  output logic signed [31:0]  final_score
);
  typedef enum logic [2:0] {
    S_IDLE, S_STAGE, S_RD, S_FEAT, S_LOOK, S_ACC, S_CHECK
  } state_t;

  logic [15:0] feat_mem  [bsc_pkg::Features];
  logic [8:0]  sel_mem   [bsc_pkg::Stumps];
  logic [15:0] thr_mem   [bsc_pkg::Stumps];
  logic [15:0] wgt_mem   [bsc_pkg::Stumps];
  logic [15:0] pos_mem   [bsc_pkg::Stumps];
  logic [15:0] neg_mem   [bsc_pkg::Stumps];
  logic [7:0]  ssz_mem   [bsc_pkg::Stages];
  logic [15:0] sth_mem   [bsc_pkg::Stages];

  state_t state;
  logic [bsc_pkg::SkW:0]  k, stage_end;
  logic [bsc_pkg::SgW:0]  s, n;
  logic signed [31:0]     sum;
  logic [8:0]  r_sel;
  logic [15:0] r_thr, r_wgt, r_pos, r_neg, r_feat, r_sth;
  logic [7:0]  r_ssz;
  logic        hit;
  logic signed [16:0] so;
  logic [bsc_pkg::SkW+1:0] end_raw;

  // loads retire only while the walk is idle; an evaluate leaves the queue when its walk starts
  assign q_take = q_valid && (state == S_IDLE) &&
                  ((q_cmd.action != bsc_pkg::ACT_EVALUATE) || !out_valid);

  // store writes
  always_ff @(posedge clk) begin
    if (q_take) begin
      unique case (q_cmd.action)
        bsc_pkg::ACT_LOAD_FEATURE: feat_mem[q_cmd.entry_index[bsc_pkg::FiW-1:0]]
                                     <= q_cmd.feature_value;
        bsc_pkg::ACT_LOAD_STUMP: begin
          sel_mem[q_cmd.entry_index[bsc_pkg::SkW-1:0]] <=
            {q_cmd.stump_dir_negative, q_cmd.stump_feature};
          thr_mem[q_cmd.entry_index[bsc_pkg::SkW-1:0]] <= q_cmd.stump_thresh;
          wgt_mem[q_cmd.entry_index[bsc_pkg::SkW-1:0]] <= q_cmd.stump_weight;
          pos_mem[q_cmd.entry_index[bsc_pkg::SkW-1:0]] <= q_cmd.stump_pos_out;
          neg_mem[q_cmd.entry_index[bsc_pkg::SkW-1:0]] <= q_cmd.stump_neg_out;
        end
        bsc_pkg::ACT_LOAD_STAGE: if (q_cmd.entry_index < 8'(bsc_pkg::Stages)) begin
          ssz_mem[q_cmd.entry_index[bsc_pkg::SgW-1:0]] <= q_cmd.stage_size;
          sth_mem[q_cmd.entry_index[bsc_pkg::SgW-1:0]] <= q_cmd.stage_thresh;
        end
        default: ;
      endcase
    end
  end

  // registered memory reads
  always_ff @(posedge clk) begin
    r_ssz  <= ssz_mem[s[bsc_pkg::SgW-1:0]];
    r_sth  <= sth_mem[s[bsc_pkg::SgW-1:0]];
    r_sel  <= sel_mem[k[bsc_pkg::SkW-1:0]];
    r_thr  <= thr_mem[k[bsc_pkg::SkW-1:0]];
    r_wgt  <= wgt_mem[k[bsc_pkg::SkW-1:0]];
    r_pos  <= pos_mem[k[bsc_pkg::SkW-1:0]];
    r_neg  <= neg_mem[k[bsc_pkg::SkW-1:0]];
    r_feat <= feat_mem[r_sel[bsc_pkg::FiW-1:0]];
  end

  // stump output
  always_comb begin
    if (boost_mode) begin
      hit = $signed(r_feat) < $signed(r_thr);
      so  = hit ? 17'($signed(r_pos)) : 17'($signed(r_neg));
    end else begin
      hit = r_sel[8] ? ($signed(r_feat) > $signed(r_thr))
                     : ($signed(r_feat) < $signed(r_thr));
      so  = hit ? 17'($signed(r_wgt)) : -17'($signed(r_wgt));
    end
    end_raw = (bsc_pkg::SkW+2)'(k) + (bsc_pkg::SkW+2)'(r_ssz);
  end

  // walk sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (q_valid && q_cmd.action == bsc_pkg::ACT_EVALUATE && !out_valid) begin
          n   <= (stages_in_use > 5'(bsc_pkg::Stages)) ? (bsc_pkg::SgW+1)'(bsc_pkg::Stages)
                                                       : (bsc_pkg::SgW+1)'(stages_in_use);
          s   <= '0;
          k   <= '0;
          sum <= '0;
          state <= S_STAGE;
        end
        S_STAGE: begin
          if (s == n) begin
            out_valid <= 1'b1;
            rejected <= 1'b0;
            reject_stage <= '0;
            final_score <= sum;
            state <= S_IDLE;
          end else state <= S_RD;
        end
        S_RD: begin
          stage_end <= (end_raw > (bsc_pkg::SkW+2)'(bsc_pkg::Stumps))
                       ? (bsc_pkg::SkW+1)'(bsc_pkg::Stumps) : end_raw[bsc_pkg::SkW:0];
          sum <= '0;
          state <= S_FEAT;
        end
        S_FEAT: state <= (k == stage_end) ? S_CHECK : S_LOOK;
        // stump entry is registered, feature read follows from its index
        S_LOOK: state <= S_ACC;
        S_ACC: begin
          sum <= bsc_pkg::sat_add(sum, so);
          k <= k + 1'b1;
          state <= S_FEAT;
        end
        S_CHECK: begin
          if (sum < 32'($signed(r_sth))) begin
            out_valid <= 1'b1;
            rejected <= 1'b1;
            reject_stage <= s[3:0];
            final_score <= '0;
            state <= S_IDLE;
          end else begin
            s <= s + 1'b1;
            state <= S_STAGE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/boosted_stump_cascade_eval.sv =====
// top level of the boosted stump cascade evaluator
// An evaluate walks the stump table one stump at a time, stage by stage, all
// through one read port per store.
// A two-entry queue lets loads be accepted while an evaluation is running.
module boosted_stump_cascade_eval (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         action,
  input  logic [7:0]         entry_index,
  input  logic signed [15:0] feature_value,
  input  logic [7:0]         stump_feature,
  input  logic               stump_dir_negative,
  input  logic signed [15:0] stump_thresh,
  input  logic signed [15:0] stump_weight,
  input  logic signed [15:0] stump_pos_out,
  input  logic signed [15:0] stump_neg_out,
  input  logic [7:0]         stage_size,
  input  logic signed [15:0] stage_thresh,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               rejected,
  output logic [3:0]         reject_stage,
  output logic signed [31:0] final_score
);
  logic          boost_mode;
  logic [4:0]    stages_in_use;
  bsc_pkg::cmd_t in_cmd, q_cmd;
  logic          q_valid, q_take;

  assign pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      boost_mode <= 1'b1;
      stages_in_use <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == bsc_pkg::REG_STAGES[0]) stages_in_use <= pwdata[4:0];
      else boost_mode <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == bsc_pkg::REG_BOOST_MODE[0]) ? {31'd0, boost_mode}
                                                          : {27'd0, stages_in_use};

  assign in_cmd = '{action: bsc_pkg::action_t'(action), entry_index: entry_index,
                    feature_value: feature_value, stump_feature: stump_feature,
                    stump_dir_negative: stump_dir_negative, stump_thresh: stump_thresh,
                    stump_weight: stump_weight, stump_pos_out: stump_pos_out,
                    stump_neg_out: stump_neg_out, stage_size: stage_size,
                    stage_thresh: stage_thresh};

  bsc_front u_front (.clk, .rst, .in_valid, .in_stall, .in_cmd,
                     .q_valid, .q_take, .q_cmd);

  bsc_back u_back (.clk, .rst, .q_valid, .q_take, .q_cmd, .boost_mode, .stages_in_use,
                   .out_valid, .out_stall, .rejected, .reject_stage, .final_score);
endmodule

// ===== rtl/bsc_checker.sv =====
// port-level checker for the cascade evaluator, bound to the top level
`include "boosted_stump_cascade_eval_macros.svh"
module bsc_checker (
  input logic              clk,
  input logic              rst,
  input logic              pready,
  input logic              out_valid,
  input logic              out_stall,
  input logic              rejected,
  input logic signed [31:0] final_score
);
  `BSC_ASSERT_IMPL(a_pready, clk, rst, 1'b1, pready)
  `BSC_ASSERT_IMPL(a_rej_zero, clk, rst, out_valid && rejected, final_score == 32'sd0)
  `BSC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(final_score))
endmodule

bind boosted_stump_cascade_eval bsc_checker u_bsc_checker (
  .clk, .rst, .pready, .out_valid, .out_stall, .rejected, .final_score);

// ===== tb/boosted_stump_cascade_eval_checker.sv =====
// scoreboard for the stump cascade evaluator: predicts and compares results
module boosted_stump_cascade_eval_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         action,
  input  logic [7:0]         entry_index,
  input  logic signed [15:0] feature_value,
  input  logic [7:0]         stump_feature,
  input  logic               stump_dir_negative,
  input  logic signed [15:0] stump_thresh,
  input  logic signed [15:0] stump_weight,
  input  logic signed [15:0] stump_pos_out,
  input  logic signed [15:0] stump_neg_out,
  input  logic [7:0]         stage_size,
  input  logic signed [15:0] stage_thresh,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               rejected,
  input  logic [3:0]         reject_stage,
  input  logic signed [31:0] final_score,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic              rejected;
    logic [3:0]        reject_stage;
    logic signed [31:0] final_score;
  } verdict_t;

  // shadow copies of the block's stores and registers
  logic signed [15:0] feat_mem [bsc_pkg::Features];
  logic [7:0]         st_feat  [bsc_pkg::Stumps];
  logic               st_neg   [bsc_pkg::Stumps];
  logic signed [15:0] st_thr   [bsc_pkg::Stumps];
  logic signed [15:0] st_wgt   [bsc_pkg::Stumps];
  logic signed [15:0] st_pos   [bsc_pkg::Stumps];
  logic signed [15:0] st_negv  [bsc_pkg::Stumps];
  logic [7:0]         sg_size  [bsc_pkg::Stages];
  logic signed [15:0] sg_thr   [bsc_pkg::Stages];
  logic               mode_real;
  logic [4:0]         stage_count;
  verdict_t           verdicts_due [$];

  assign pending = verdicts_due.size();

  // contribution of one stump under the current mode
  function automatic longint stump_vote(int k);
    longint f, t;
    logic hit;
    f = feat_mem[st_feat[k]];
    t = st_thr[k];
    if (mode_real) return (f < t) ? longint'(st_pos[k]) : longint'(st_negv[k]);
    hit = st_neg[k] ? (f > t) : (f < t);
    return hit ? longint'(st_wgt[k]) : -longint'(st_wgt[k]);
  endfunction

  // walk the cascade and form the verdict
  function automatic verdict_t cascade_verdict();
    verdict_t v;
    int n, base, stop;
    longint acc;
    v = '0;
    acc = 0;
    base = 0;
    n = (stage_count > bsc_pkg::Stages) ? bsc_pkg::Stages : stage_count;
    for (int s = 0; s < n; s++) begin
      stop = base + sg_size[s];
      if (stop > bsc_pkg::Stumps) stop = bsc_pkg::Stumps;
      acc = 0;
      for (int k = base; k < stop; k++) begin
        acc += stump_vote(k);
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      end
      if (acc < longint'(sg_thr[s])) begin
        v.rejected = 1'b1;
        v.reject_stage = s[3:0];
        return v;
      end
      base = stop;
    end
    v.final_score = acc[31:0];
    return v;
  endfunction

  initial fail_count = 0;

  always @(posedge clk) begin
    verdict_t got, want;
    if (rst) begin
      mode_real <= 1'b1;
      stage_count <= '0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr == 3'(bsc_pkg::REG_BOOST_MODE) * 3'd4) mode_real <= pwdata[0];
        else if (paddr == 3'(bsc_pkg::REG_STAGES) * 3'd4) stage_count <= pwdata[4:0];
      end
      // accepted input transaction
      if (in_valid && !in_stall) begin
        case (bsc_pkg::action_t'(action))
          bsc_pkg::ACT_LOAD_FEATURE: feat_mem[entry_index] = feature_value;
          bsc_pkg::ACT_LOAD_STUMP: begin
            st_feat[entry_index] = stump_feature;
            st_neg[entry_index]  = stump_dir_negative;
            st_thr[entry_index]  = stump_thresh;
            st_wgt[entry_index]  = stump_weight;
            st_pos[entry_index]  = stump_pos_out;
            st_negv[entry_index] = stump_neg_out;
          end
          bsc_pkg::ACT_LOAD_STAGE: begin
            if (entry_index < bsc_pkg::Stages) begin
              sg_size[entry_index[3:0]] = stage_size;
              sg_thr[entry_index[3:0]]  = stage_thresh;
            end
          end
          bsc_pkg::ACT_EVALUATE:
            verdicts_due.insert(verdicts_due.size(), cascade_verdict());
          default: ;
        endcase
      end
      // accepted result transaction
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          $error("unexpected result transaction");
          fail_count++;
        end else begin
          want = verdicts_due.pop_front();
          got = '{rejected, reject_stage, final_score};
          if (got.rejected !== want.rejected) begin
            $error("rejected: expected %0d actual %0d", want.rejected, got.rejected);
            fail_count++;
          end
          if (got.reject_stage !== want.reject_stage) begin
            $error("reject_stage: expected %0d actual %0d",
                   want.reject_stage, got.reject_stage);
            fail_count++;
          end
          if (got.final_score !== want.final_score) begin
            $error("final_score: expected %0d actual %0d",
                   want.final_score, got.final_score);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ===== tb/boosted_stump_cascade_eval_test.sv =====
// stimulus and verdict for the stump cascade evaluator
module boosted_stump_cascade_eval_test;

  localparam int IdleLimit = 20000;
  localparam int HoldCycles = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] action = '0;
  logic [7:0] entry_index = '0;
  logic signed [15:0] feature_value = '0;
  logic [7:0] stump_feature = '0;
  logic stump_dir_negative = 1'b0;
  logic signed [15:0] stump_thresh = '0, stump_weight = '0;
  logic signed [15:0] stump_pos_out = '0, stump_neg_out = '0;
  logic [7:0] stage_size = '0;
  logic signed [15:0] stage_thresh = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic rejected;
  logic [3:0] reject_stage;
  logic signed [31:0] final_score;
  int fail_count, pending;
  int sent = 0;
  logic calm = 1'b0;
  int idle_cycles = 0;

  boosted_stump_cascade_eval DUT (.*);
  boosted_stump_cascade_eval_checker checker_i (.*);

  initial forever #5 clk = ~clk;

  // random stalls on the result side, with one long hold-off
  initial begin
    logic held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (calm) begin
        out_stall <= 1'b0;
      end else if (!held && sent >= 600) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 20)) @(posedge clk);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("boosted_stump_cascade_eval test failed");
      $finish;
    end
  end

  // one register write, setup then access
  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(idx) * 3'd4; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // offer one input transaction and wait for it to be taken
  task automatic offer(bsc_pkg::cmd_t c);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    action <= c.action; entry_index <= c.entry_index;
    feature_value <= c.feature_value; stump_feature <= c.stump_feature;
    stump_dir_negative <= c.stump_dir_negative; stump_thresh <= c.stump_thresh;
    stump_weight <= c.stump_weight; stump_pos_out <= c.stump_pos_out;
    stump_neg_out <= c.stump_neg_out; stage_size <= c.stage_size;
    stage_thresh <= c.stage_thresh;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // random content in every field, action chosen by caller
  function automatic bsc_pkg::cmd_t random_cmd(bsc_pkg::action_t a);
    bsc_pkg::cmd_t c;
    c = bsc_pkg::cmd_t'($bits(bsc_pkg::cmd_t)'({$urandom, $urandom, $urandom,
                                                 $urandom, $urandom}));
    c.action = a;
    case ($urandom_range(0, 3))
      0: c.stage_thresh = -16'sd32768;
      1: c.stage_thresh = 16'($signed($urandom_range(0, 4000)) - 2000);
      default: ;
    endcase
    if (a == bsc_pkg::ACT_LOAD_STAGE) begin
      c.entry_index = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(16, 255))
                                                  : 8'($urandom_range(0, 15));
      if ($urandom_range(0, 2) != 0) c.stage_size = 8'($urandom_range(0, 24));
    end
    return c;
  endfunction

  // drain outstanding results before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  initial begin
    bsc_pkg::cmd_t c;
    logic [4:0] phase_stages [6];
    logic phase_mode [6];
    phase_stages = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd5, 5'd16};
    phase_mode = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    reg_write(bsc_pkg::REG_BOOST_MODE, 32'd0);
    reg_write(bsc_pkg::REG_STAGES, 32'd16);

    // fill every store so that no entry is read unwritten
    for (int i = 0; i < bsc_pkg::Features; i++) begin
      c = random_cmd(bsc_pkg::ACT_LOAD_FEATURE);
      c.entry_index = 8'(i);
      offer(c);
    end
    for (int i = 0; i < bsc_pkg::Stumps; i++) begin
      c = random_cmd(bsc_pkg::ACT_LOAD_STUMP);
      c.entry_index = 8'(i);
      offer(c);
    end
    for (int i = 0; i < bsc_pkg::Stages; i++) begin
      c = random_cmd(bsc_pkg::ACT_LOAD_STAGE);
      c.entry_index = 8'(i);
      c.stage_size = 8'($urandom_range(0, 20));
      offer(c);
    end

    // directed: field extremes, empty and clipped stages, ignored slot
    c = random_cmd(bsc_pkg::ACT_LOAD_FEATURE);
    c.entry_index = 8'd0; c.feature_value = -16'sd32768; offer(c);
    c.entry_index = 8'd255; c.feature_value = 16'sd32767; offer(c);
    c = random_cmd(bsc_pkg::ACT_LOAD_STUMP);
    c.entry_index = 8'd0; c.stump_feature = 8'd255; c.stump_dir_negative = 1'b1;
    c.stump_thresh = 16'sd32767; c.stump_weight = -16'sd32768; offer(c);
    c.entry_index = 8'd255; c.stump_feature = 8'd0; c.stump_dir_negative = 1'b0;
    c.stump_thresh = -16'sd32768; c.stump_weight = 16'sd32767;
    c.stump_pos_out = -16'sd32768; c.stump_neg_out = 16'sd32767; offer(c);
    c = random_cmd(bsc_pkg::ACT_LOAD_STAGE);
    c.entry_index = 8'd200; c.stage_size = 8'd255; offer(c);
    c.entry_index = 8'd0; c.stage_size = 8'd0; c.stage_thresh = -16'sd32768; offer(c);
    c.entry_index = 8'd1; c.stage_size = 8'd255; offer(c);
    c.entry_index = 8'd2; c.stage_size = 8'd255; c.stage_thresh = 16'sd32767; offer(c);
    offer(random_cmd(bsc_pkg::ACT_EVALUATE));
    c.entry_index = 8'd2; c.stage_thresh = -16'sd32768; offer(c);
    offer(random_cmd(bsc_pkg::ACT_EVALUATE));
    c.entry_index = 8'd1; c.stage_size = 8'd10; offer(c);
    c.entry_index = 8'd15; c.stage_size = 8'd255; c.stage_thresh = 16'sd32767; offer(c);
    offer(random_cmd(bsc_pkg::ACT_EVALUATE));

    // random phases over register settings
    for (int p = 0; p < 6; p++) begin
      settle();
      reg_write(bsc_pkg::REG_BOOST_MODE, 32'(phase_mode[p]));
      reg_write(bsc_pkg::REG_STAGES, 32'(phase_stages[p]));
      if (p == 5) calm = 1'b1;
      repeat (130) begin
        case ($urandom_range(0, 9))
          0, 1: offer(random_cmd(bsc_pkg::ACT_LOAD_FEATURE));
          2, 3: offer(random_cmd(bsc_pkg::ACT_LOAD_STUMP));
          4, 5: offer(random_cmd(bsc_pkg::ACT_LOAD_STAGE));
          default: offer(random_cmd(bsc_pkg::ACT_EVALUATE));
        endcase
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (900) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("boosted_stump_cascade_eval test passed");
    end else begin
      $display("boosted_stump_cascade_eval test failed");
    end
    $finish;
  end

endmodule
